// File: rtl/pptr_pkg.sv
// pptr_pkg: register map, command codes and shared types for the
// parallel port / timer register block. No dependencies.
`timescale 1ns / 1ps

package pptr_pkg;

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // register byte addresses
    localparam logic [4:0] ADDR_VEC_PORT = 5'd5;
    localparam logic [4:0] ADDR_DIR_A    = 5'd2;
    localparam logic [4:0] ADDR_DIR_B    = 5'd3;
    localparam logic [4:0] ADDR_DIR_C    = 5'd4;
    localparam logic [4:0] ADDR_DATA_A   = 5'd8;
    localparam logic [4:0] ADDR_DATA_B   = 5'd9;
    localparam logic [4:0] ADDR_ALT_A    = 5'd10;
    localparam logic [4:0] ADDR_ALT_B    = 5'd11;
    localparam logic [4:0] ADDR_DATA_C   = 5'd12;
    localparam logic [4:0] ADDR_TCR      = 5'd16;
    localparam logic [4:0] ADDR_TVEC     = 5'd17;
    localparam logic [4:0] ADDR_NULL0    = 5'd18;
    localparam logic [4:0] ADDR_PRE_H    = 5'd19;
    localparam logic [4:0] ADDR_PRE_M    = 5'd20;
    localparam logic [4:0] ADDR_PRE_L    = 5'd21;
    localparam logic [4:0] ADDR_NULL1    = 5'd22;
    localparam logic [4:0] ADDR_CNT_H    = 5'd23;
    localparam logic [4:0] ADDR_CNT_M    = 5'd24;
    localparam logic [4:0] ADDR_CNT_L    = 5'd25;
    localparam logic [4:0] ADDR_TSR      = 5'd26;

    localparam int unsigned NUM_REGS = 32;

    // port select codes
    localparam logic [1:0] PSEL_A = 2'd0;
    localparam logic [1:0] PSEL_B = 2'd1;
    localparam logic [1:0] PSEL_C = 2'd2;

    localparam logic [7:0] TCR_WR_MASK   = 8'hF7;
    localparam logic [7:0] TCR_MODE_MASK = 8'h06;
    localparam logic [7:0] VECTOR_RESET  = 8'h0F;

    // what the timer does on this word
    typedef struct packed {
        logic        fire;     // prescaler wrapped, counter acts
        logic        zero;     // counter was zero: reload and set status
        logic [23:0] count_dec;
    } timer_upd_t;

endpackage

// File: rtl/pptr_timer.sv
// pptr_timer: input-clock prescaler and 24-bit down-counter decision logic.
// Depends on pptr_pkg.
`timescale 1ns / 1ps

module pptr_timer #(
    parameter int unsigned PRESCALE_DIV = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  logic [7:0]          tcr,
    input  logic [23:0]         count,
    output pptr_pkg::timer_upd_t upd
);

    localparam int unsigned PS_W = (PRESCALE_DIV > 2) ? $clog2(PRESCALE_DIV) : 1;
    localparam logic [PS_W-1:0] PS_LAST = PS_W'(PRESCALE_DIV - 1);

    logic [PS_W-1:0] ps_reg;
    logic [PS_W-1:0] ps_next;
    logic            enable;
    logic            wrap;

    // enabled, prescaled clock mode
    assign enable = tick && tcr[0] && ((tcr & pptr_pkg::TCR_MODE_MASK) == 8'h00);
    assign wrap   = enable && (ps_reg == PS_LAST);

    always_comb
    begin
        ps_next = ps_reg;
        if (wrap)
        begin
            ps_next = '0;
        end
        else if (enable)
        begin
            ps_next = ps_reg + PS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg <= '0;
        end
        else
        begin
            ps_reg <= ps_next;
        end
    end

    assign upd.fire      = wrap;
    assign upd.zero      = (count == 24'd0);
    assign upd.count_dec = count - 24'd1;

endmodule

// File: rtl/parallel_port_timer_registers.sv
// parallel_port_timer_registers: 32-byte register file of a parallel port
// and timer peripheral. Depends on pptr_pkg and pptr_timer.
`timescale 1ns / 1ps
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+----
//  in      | in_valid, in_ready, command, address, write_data,  | in
//          | pins_a, pins_b, pins_c                            |
//  out     | out_valid, out_ready, read_data, port_write_valid, | out
//          | port_write_select, port_write_value, timer_irq,   |
//          | timer_vector                                      |
//
// One word per cycle unless stalled: each accepted word updates the register
// file and loads the result register on the same edge. in_ready is high when
// the result register is empty or being taken, so a stalled output holds one
// result and blocks input only until it drains. Reset clears the register
// file, the prescaler and out_valid; the two vector bytes come up as 0x0F.

module parallel_port_timer_registers #(
    parameter int unsigned PRESCALE_DIV = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [4:0] address,
    input  logic [7:0] write_data,
    input  logic [7:0] pins_a,
    input  logic [7:0] pins_b,
    input  logic [7:0] pins_c,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       port_write_valid,
    output logic [1:0] port_write_select,
    output logic [7:0] port_write_value,
    output logic       timer_irq,
    output logic [7:0] timer_vector
);

    logic [7:0] regs_reg  [pptr_pkg::NUM_REGS];
    logic [7:0] regs_next [pptr_pkg::NUM_REGS];

    logic       out_valid_reg;
    logic [7:0] rd_reg;
    logic       pvalid_reg;
    logic [1:0] psel_reg;
    logic [7:0] pval_reg;
    logic       irq_reg;
    logic [7:0] vec_reg;

    logic       accept;
    logic [7:0] rd_next;
    logic       pvalid_next;
    logic [1:0] psel_next;
    logic [7:0] pval_next;
    logic [7:0] wval;
    logic [7:0] pin_sel;
    logic [7:0] dir_sel;
    logic       mixed;
    logic [23:0] count;
    logic [23:0] preload;

    pptr_pkg::timer_upd_t tupd;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign count   = {regs_reg[pptr_pkg::ADDR_CNT_H], regs_reg[pptr_pkg::ADDR_CNT_M],
                      regs_reg[pptr_pkg::ADDR_CNT_L]};
    assign preload = {regs_reg[pptr_pkg::ADDR_PRE_H], regs_reg[pptr_pkg::ADDR_PRE_M],
                      regs_reg[pptr_pkg::ADDR_PRE_L]};

    pptr_timer #(
        .PRESCALE_DIV (PRESCALE_DIV)
    ) u_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (accept && (command == pptr_pkg::CMD_TICK)),
        .tcr   (regs_reg[pptr_pkg::ADDR_TCR]),
        .count (count),
        .upd   (tupd)
    );

    // pin/direction pairing for data and alternate registers
    always_comb
    begin
        mixed   = 1'b1;
        pin_sel = pins_a;
        dir_sel = regs_reg[pptr_pkg::ADDR_DIR_A];
        case (address)
            pptr_pkg::ADDR_DATA_A, pptr_pkg::ADDR_ALT_A:
            begin
                pin_sel = pins_a;
                dir_sel = regs_reg[pptr_pkg::ADDR_DIR_A];
            end
            pptr_pkg::ADDR_DATA_B, pptr_pkg::ADDR_ALT_B:
            begin
                pin_sel = pins_b;
                dir_sel = regs_reg[pptr_pkg::ADDR_DIR_B];
            end
            pptr_pkg::ADDR_DATA_C:
            begin
                pin_sel = pins_c;
                dir_sel = regs_reg[pptr_pkg::ADDR_DIR_C];
            end
            default:
            begin
                mixed = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < pptr_pkg::NUM_REGS; i++)
        begin
            regs_next[i] = regs_reg[i];
        end
        rd_next     = 8'h00;
        pvalid_next = 1'b0;
        psel_next   = pptr_pkg::PSEL_A;
        pval_next   = 8'h00;
        wval        = write_data;

        case (command)
            pptr_pkg::CMD_READ:
            begin
                if (mixed)
                begin
                    rd_next = (pin_sel & ~dir_sel) | (regs_reg[address] & dir_sel);
                end
                else if (address == pptr_pkg::ADDR_NULL0 || address == pptr_pkg::ADDR_NULL1)
                begin
                    rd_next = 8'h00;
                end
                else
                begin
                    rd_next = regs_reg[address];
                end
            end
            pptr_pkg::CMD_WRITE:
            begin
                if (address != pptr_pkg::ADDR_CNT_H && address != pptr_pkg::ADDR_CNT_M &&
                    address != pptr_pkg::ADDR_CNT_L)
                begin
                    if (address == pptr_pkg::ADDR_DATA_A)
                    begin
                        pvalid_next = 1'b1;
                        psel_next   = pptr_pkg::PSEL_A;
                        pval_next   = write_data;
                    end
                    else if (address == pptr_pkg::ADDR_DATA_B)
                    begin
                        pvalid_next = 1'b1;
                        psel_next   = pptr_pkg::PSEL_B;
                        pval_next   = write_data;
                    end
                    else if (address == pptr_pkg::ADDR_DATA_C)
                    begin
                        pvalid_next = 1'b1;
                        psel_next   = pptr_pkg::PSEL_C;
                        pval_next   = write_data;
                    end
                    if (address == pptr_pkg::ADDR_TCR)
                    begin
                        wval = write_data & pptr_pkg::TCR_WR_MASK;
                    end
                    else if (address == pptr_pkg::ADDR_TSR)
                    begin
                        wval = 8'h00;
                    end
                    regs_next[address] = wval;
                end
            end
            pptr_pkg::CMD_TICK:
            begin
                if (tupd.fire)
                begin
                    if (tupd.zero)
                    begin
                        regs_next[pptr_pkg::ADDR_TSR]   = 8'h01;
                        regs_next[pptr_pkg::ADDR_CNT_H] = preload[23:16];
                        regs_next[pptr_pkg::ADDR_CNT_M] = preload[15:8];
                        regs_next[pptr_pkg::ADDR_CNT_L] = preload[7:0];
                    end
                    else
                    begin
                        regs_next[pptr_pkg::ADDR_CNT_H] = tupd.count_dec[23:16];
                        regs_next[pptr_pkg::ADDR_CNT_M] = tupd.count_dec[15:8];
                        regs_next[pptr_pkg::ADDR_CNT_L] = tupd.count_dec[7:0];
                    end
                end
            end
            default:
            begin
                rd_next = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pptr_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= 8'h00;
            end
            regs_reg[pptr_pkg::ADDR_VEC_PORT] <= pptr_pkg::VECTOR_RESET;
            regs_reg[pptr_pkg::ADDR_TVEC]     <= pptr_pkg::VECTOR_RESET;
        end
        else if (accept)
        begin
            for (int i = 0; i < pptr_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= regs_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg     <= rd_next;
            pvalid_reg <= pvalid_next;
            psel_reg   <= psel_next;
            pval_reg   <= pval_next;
            irq_reg    <= regs_next[pptr_pkg::ADDR_TSR][0];
            vec_reg    <= regs_next[pptr_pkg::ADDR_TVEC];
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = rd_reg;
    assign port_write_valid  = pvalid_reg;
    assign port_write_select = psel_reg;
    assign port_write_value  = pval_reg;
    assign timer_irq         = irq_reg;
    assign timer_vector      = vec_reg;

endmodule
